>>> sv/urc_pkg.sv
package urc_pkg;

    // Sequencer phases
    typedef enum logic [1:0] {
        PH_TRIG = 2'd0,
        PH_WAIT = 2'd1,
        PH_MEAS = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_RUN_ENABLE   = 3'd0,
        CFG_TRIGGER      = 3'd1,
        CFG_ECHO_WINDOW  = 3'd2,
        CFG_PERIOD       = 3'd3,
        CFG_CM_PER_TICK  = 3'd4
    } t_cfg_reg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int TRIG_W     = 10;
    localparam int WIN_W      = 20;
    localparam int PER_W      = 20;
    localparam int SCALE_W    = 16;
    localparam int RANGE_W    = 10;
    localparam int CHAR_W     = 6;

    localparam logic [TRIG_W-1:0]  TRIG_RESET  = 10'd10;
    localparam logic [WIN_W-1:0]   WIN_RESET   = 20'd100000;
    localparam logic [PER_W-1:0]   PER_RESET   = 20'd200000;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1124;

    localparam logic [RANGE_W-1:0] RANGE_MAX   = 10'd999;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;

    // One tick's event as it moves down the pipeline
    typedef struct packed {
        logic valid;
        logic trig;
        logic ready;
        logic timeout;
    } t_event;

endpackage

>>> sv/urc_sequencer.sv
module urc_sequencer
    import urc_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic                  i_accept,
    input  logic                  i_echo,
    input  logic                  i_run,
    input  logic [TRIG_W-1:0]     i_trigger_ticks,
    input  logic [WIN_W-1:0]      i_window_ticks,
    input  logic [PER_W-1:0]      i_period_ticks,
    output t_event                o_ev,
    output logic [COUNT_BITS-1:0] o_count
);

    // compare width covers both the counters and the 20-bit settings, plus a carry
    localparam int CW = ((COUNT_BITS > PER_W) ? COUNT_BITS : PER_W) + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_cycle, n_cycle;
    logic [COUNT_BITS-1:0] r_echo_cnt, n_echo_cnt;
    logic                  r_last_echo;
    t_event                r_ev, n_ev;
    logic [COUNT_BITS-1:0] r_count;

    logic [CW-1:0] tt_w, win_w, per_w, c_w, c_inc, wait_el;
    logic          rise;

    // clamp the settings to their legal minimum
    always_comb begin
        tt_w  = (i_trigger_ticks == '0) ? CW'(1) : CW'(i_trigger_ticks);
        win_w = (i_window_ticks == '0) ? CW'(1) : CW'(i_window_ticks);
        per_w = (i_period_ticks < PER_W'(2)) ? CW'(2) : CW'(i_period_ticks);
        c_w   = CW'(r_cycle);
        c_inc = c_w + CW'(1);
        wait_el = (c_w >= tt_w) ? (c_w - tt_w) : '0;
        rise  = i_echo & ~r_last_echo;
    end

    // next state and event for one tick
    always_comb begin
        n_phase    = r_phase;
        n_cycle    = r_cycle;
        n_echo_cnt = r_echo_cnt;
        n_ev       = '0;
        n_ev.valid = i_accept;
        if (!i_run) begin
            n_phase    = PH_TRIG;
            n_cycle    = '0;
            n_echo_cnt = '0;
        end else begin
            unique case (r_phase)
                PH_TRIG: begin
                    n_ev.trig = 1'b1;
                    if (c_inc >= tt_w) begin
                        n_phase = PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    if (rise) begin
                        n_phase    = PH_MEAS;
                        n_echo_cnt = COUNT_BITS'(1);
                    end else if (wait_el + CW'(1) >= win_w) begin
                        n_ev.ready   = 1'b1;
                        n_ev.timeout = 1'b1;
                        n_phase      = PH_DONE;
                    end
                end
                PH_MEAS: begin
                    if (i_echo) begin
                        if (r_echo_cnt != CNT_MAX) begin
                            n_echo_cnt = r_echo_cnt + COUNT_BITS'(1);
                        end
                    end else begin
                        n_ev.ready = 1'b1;
                        n_phase    = PH_DONE;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase

            // period end: abort an unfinished measurement and restart
            if (c_inc >= per_w || r_cycle == CNT_MAX) begin
                if (!n_ev.ready && (n_phase == PH_WAIT || n_phase == PH_MEAS)) begin
                    n_ev.ready   = 1'b1;
                    n_ev.timeout = 1'b1;
                end
                n_phase    = PH_TRIG;
                n_cycle    = '0;
                n_echo_cnt = '0;
            end else begin
                n_cycle = r_cycle + COUNT_BITS'(1);
            end
        end
    end

    // state registers, moved on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TRIG;
            r_cycle     <= '0;
            r_echo_cnt  <= '0;
            r_last_echo <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_cycle     <= n_cycle;
            r_echo_cnt  <= n_echo_cnt;
            r_last_echo <= i_echo;
        end
    end

    // stage 1 event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= '0;
        end else if (i_advance) begin
            r_ev <= n_ev;
        end
    end

    // count measured so far, used only with a measurement event
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_count <= r_echo_cnt;
        end
    end

    assign o_ev    = r_ev;
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_meas_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_MEAS |-> r_echo_cnt != '0)
        else $error("measuring with zero echo count");

    a_disabled_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_run |=> !r_ev.ready && !r_ev.trig)
        else $error("result or trigger while disabled");
`endif

endmodule

>>> sv/urc_scaler.sv
module urc_scaler
    import urc_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  t_event                i_ev,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [SCALE_W-1:0]    i_scale,
    output t_event                o_ev,
    output logic [RANGE_W-1:0]    o_range,
    output logic                  o_timed_out
);

    localparam int PW = COUNT_BITS + SCALE_W;
    // rounded value is at least as wide as the range so the saturation compare fits
    localparam int RW = ((COUNT_BITS + 1) > RANGE_W) ? (COUNT_BITS + 1) : RANGE_W;

    t_event               r_ev2, r_ev3;
    logic [PW-1:0]        r_prod;
    logic [RANGE_W-1:0]   r_held_range;
    logic                 r_held_to;

    logic [PW:0]          sum;
    logic [RW-1:0]        rounded;
    logic [RANGE_W-1:0]   sat;

    // stage 2: ticks times Q16 scale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev2 <= '0;
        end else if (i_advance) begin
            r_ev2 <= i_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_prod <= PW'(i_count) * PW'(i_scale);
        end
    end

    // round to nearest centimetre and saturate
    always_comb begin
        sum     = {1'b0, r_prod} + (PW+1)'(32768);
        rounded = RW'(sum[PW:SCALE_W]);
        sat     = (rounded > RW'(RANGE_MAX)) ? RANGE_MAX : rounded[RANGE_W-1:0];
    end

    // stage 3: held result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev3        <= '0;
            r_held_range <= '0;
            r_held_to    <= 1'b0;
        end else if (i_advance) begin
            r_ev3 <= r_ev2;
            if (r_ev2.valid && r_ev2.ready) begin
                r_held_range <= r_ev2.timeout ? RANGE_MAX : sat;
                r_held_to    <= r_ev2.timeout;
            end
        end
    end

    assign o_ev        = r_ev3;
    assign o_range     = r_held_range;
    assign o_timed_out = r_held_to;

endmodule

>>> sv/urc_digits.sv
module urc_digits
    import urc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  t_event             i_ev,
    input  logic [RANGE_W-1:0] i_range,
    input  logic               i_timed_out,
    output logic               o_valid,
    output logic               o_trigger_level,
    output logic               o_range_ready,
    output logic               o_timed_out,
    output logic [RANGE_W-1:0] o_range_cm,
    output logic [CHAR_W-1:0]  o_hundreds_char,
    output logic [CHAR_W-1:0]  o_tens_char,
    output logic [CHAR_W-1:0]  o_ones_char
);

    logic [15:0] h_prod;
    logic [3:0]  hund;
    logic [6:0]  rem;
    logic [14:0] t_prod;
    logic [3:0]  tens;
    logic [3:0]  ones;

    logic                r_valid, r_trig, r_ready, r_to;
    logic [RANGE_W-1:0]  r_range;
    logic [CHAR_W-1:0]   r_hund, r_tens, r_ones;

    // decimal split by reciprocal multiply, exact for 0..999
    always_comb begin
        h_prod = 16'(i_range) * 16'd41;
        hund   = h_prod[15:12];
        rem    = 7'(i_range - (10'(hund) * 10'd100));
        t_prod = 15'(rem) * 15'd205;
        tens   = t_prod[14:11];
        ones   = 4'(rem - (7'(tens) * 7'd10));
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_ev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_trig  <= i_ev.trig;
            r_ready <= i_ev.ready;
            r_to    <= i_timed_out;
            r_range <= i_range;
            r_hund  <= ASCII_ZERO + CHAR_W'(hund);
            r_tens  <= ASCII_ZERO + CHAR_W'(tens);
            r_ones  <= ASCII_ZERO + CHAR_W'(ones);
        end
    end

    assign o_valid         = r_valid;
    assign o_trigger_level = r_trig;
    assign o_range_ready   = r_ready;
    assign o_timed_out     = r_to;
    assign o_range_cm      = r_range;
    assign o_hundreds_char = r_hund;
    assign o_tens_char     = r_tens;
    assign o_ones_char     = r_ones;

endmodule

>>> sv/ultrasonic_range_controller.sv
// Ultrasonic range controller for a trigger/echo ranging sensor.
// Input channel (i_in_valid / o_in_ready / i_echo_level): one transfer per
// microsecond tick carrying the sampled echo pin level.
// Output channel (o_out_valid / i_out_ready): exactly one result per input
// transfer, in order: the trigger pin level for that tick, a one-tick
// range_ready flag, the held range in cm (saturated at 999), its three ASCII
// digits and the timeout flag of the latest result.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
// always ready; write only while no tick is in flight.
// From input transfer to output valid, the transfer edge loads the sequencer
// register, then the scale multiply, round/saturate/hold and digit split
// registers load in turn. One tick is taken per cycle while the output is not stalled.
// The pipeline moves as a whole: when the receiver stalls with a result
// waiting, the output register holds and o_in_ready drops until it is taken.
// Reset clears the pipeline and loads the default settings (disabled,
// trigger 10, window 100000, period 200000, scale 1124/65536 cm per tick);
// the held range reads 0 ("000") with no timeout until the first result.
module ultrasonic_range_controller
    import urc_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_echo_level,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_trigger_level,
    output logic                  o_range_ready,
    output logic                  o_timed_out,
    output logic [RANGE_W-1:0]    o_range_cm,
    output logic [CHAR_W-1:0]     o_hundreds_char,
    output logic [CHAR_W-1:0]     o_tens_char,
    output logic [CHAR_W-1:0]     o_ones_char,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                 r_run;
    logic [TRIG_W-1:0]    r_trigger_ticks;
    logic [WIN_W-1:0]     r_window_ticks;
    logic [PER_W-1:0]     r_period_ticks;
    logic [SCALE_W-1:0]   r_scale;

    logic                  advance, accept;
    t_event                ev1, ev3;
    logic [COUNT_BITS-1:0] count1;
    logic [RANGE_W-1:0]    held_range;
    logic                  held_to;

    // whole pipeline steps when the output register is free or being drained
    assign advance    = !o_out_valid || i_out_ready;
    assign o_in_ready = advance;
    assign accept     = i_in_valid && advance;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run           <= 1'b0;
            r_trigger_ticks <= TRIG_RESET;
            r_window_ticks  <= WIN_RESET;
            r_period_ticks  <= PER_RESET;
            r_scale         <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RUN_ENABLE:  r_run           <= i_cfg_data[0];
                CFG_TRIGGER:     r_trigger_ticks <= i_cfg_data[TRIG_W-1:0];
                CFG_ECHO_WINDOW: r_window_ticks  <= i_cfg_data[WIN_W-1:0];
                CFG_PERIOD:      r_period_ticks  <= i_cfg_data[PER_W-1:0];
                CFG_CM_PER_TICK: r_scale         <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    urc_sequencer #(
        .COUNT_BITS(COUNT_BITS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_accept        (accept),
        .i_echo          (i_echo_level),
        .i_run           (r_run),
        .i_trigger_ticks (r_trigger_ticks),
        .i_window_ticks  (r_window_ticks),
        .i_period_ticks  (r_period_ticks),
        .o_ev            (ev1),
        .o_count         (count1)
    );

    urc_scaler #(
        .COUNT_BITS(COUNT_BITS)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_ev        (ev1),
        .i_count     (count1),
        .i_scale     (r_scale),
        .o_ev        (ev3),
        .o_range     (held_range),
        .o_timed_out (held_to)
    );

    urc_digits u_digits (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (advance),
        .i_ev            (ev3),
        .i_range         (held_range),
        .i_timed_out     (held_to),
        .o_valid         (o_out_valid),
        .o_trigger_level (o_trigger_level),
        .o_range_ready   (o_range_ready),
        .o_timed_out     (o_timed_out),
        .o_range_cm      (o_range_cm),
        .o_hundreds_char (o_hundreds_char),
        .o_tens_char     (o_tens_char),
        .o_ones_char     (o_ones_char)
    );

`ifndef SYNTHESIS
    a_timeout_is_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_timed_out |-> o_range_cm == RANGE_MAX)
        else $error("timeout result is not the maximum range");

    a_range_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_range_cm <= RANGE_MAX)
        else $error("range above saturation limit");

    a_digit_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hundreds_char >= ASCII_ZERO) && (o_hundreds_char <= 6'd57)
                        && (o_tens_char >= ASCII_ZERO) && (o_tens_char <= 6'd57)
                        && (o_ones_char >= ASCII_ZERO) && (o_ones_char <= 6'd57))
        else $error("digit character out of range");
`endif

endmodule
